FILE: sv/pulse_period_frequency_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse period / frequency meter
// Shared forms for concurrent checks clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_FREQUENCY_METER_ASSERT_SVH
`define PULSE_PERIOD_FREQUENCY_METER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PPFM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PPFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ppfm_pkg.sv
// ----------------------------------------------------------------------------
// ppfm_pkg
// Types, constants and the BCD shift step for the pulse period meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppfm_pkg;

  localparam int TPS_WIDTH        = 20;
  localparam int PERIOD_OUT_WIDTH = 17;
  localparam int FREQ_WIDTH       = 19;
  localparam int BCD_WIDTH        = 24;
  localparam int BCD_DIGITS       = 6;
  localparam int DIV_STEPS        = TPS_WIDTH;
  localparam int STEP_WIDTH       = $clog2(DIV_STEPS);

  localparam logic [TPS_WIDTH-1:0] TPS_RESET = 20'd1000000;
  localparam logic [TPS_WIDTH-1:0] BCD_LIMIT = 20'd999999;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_WAIT,
    PH_COUNT
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

  // One double-dabble step: correct each digit, then shift in one bit.
  function automatic logic [BCD_WIDTH-1:0] bcd_shift(input logic [BCD_WIDTH-1:0] b,
                                                      input logic bit_in);
    logic [BCD_WIDTH-1:0] adj;
    adj = b;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_WIDTH-2:0], bit_in};
  endfunction

endpackage

FILE: sv/ppfm_front.sv
// ----------------------------------------------------------------------------
// ppfm_front
// Edge tracker: skips a pulse in progress, counts high ticks with
// saturation and pushes count and overflow flag on the falling edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppfm_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic                   level,
  output logic                   push,
  output logic [COUNT_WIDTH:0]   push_data
);
  import ppfm_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  front_state_t           state, state_next;
  logic [COUNT_WIDTH-1:0] high_count, high_count_next;
  logic                   saturated, saturated_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= PH_SKIP;
      high_count <= '0;
      saturated  <= 1'b0;
    end else begin
      state      <= state_next;
      high_count <= high_count_next;
      saturated  <= saturated_next;
    end
  end

  always_comb begin
    state_next      = state;
    high_count_next = high_count;
    saturated_next  = saturated;
    push            = 1'b0;
    push_data       = {high_count, saturated};
    if (tick) begin
      unique case (state)
        PH_WAIT: begin
          if (level) begin
            state_next      = PH_COUNT;
            high_count_next = COUNT_WIDTH'(1);
            saturated_next  = 1'b0;
          end
        end
        PH_COUNT: begin
          if (level) begin
            if (high_count == COUNT_MAX) begin
              saturated_next = 1'b1;
            end else begin
              high_count_next = high_count + 1'b1;
            end
          end else begin
            push            = 1'b1;
            high_count_next = '0;
            saturated_next  = 1'b0;
            state_next      = PH_WAIT;
          end
        end
        default: begin
          state_next = level ? PH_SKIP : PH_WAIT;
        end
      endcase
    end
  end

endmodule

FILE: sv/ppfm_fifo.sv
// ----------------------------------------------------------------------------
// ppfm_fifo
// Two-entry queue between the edge tracker and the arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppfm_fifo #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/ppfm_back.sv
// ----------------------------------------------------------------------------
// ppfm_back
// Serial restoring divider for the frequency with double-dabble BCD
// conversion of period and frequency running alongside, plus result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppfm_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [ppfm_pkg::TPS_WIDTH-1:0]         tps,
  input  logic                                   entry_avail,
  input  logic [COUNT_WIDTH:0]                   entry,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ppfm_pkg::PERIOD_OUT_WIDTH-1:0]  period_ticks,
  output logic [ppfm_pkg::FREQ_WIDTH-1:0]        frequency_hz,
  output logic [ppfm_pkg::BCD_WIDTH-1:0]         period_bcd,
  output logic [ppfm_pkg::BCD_WIDTH-1:0]         frequency_bcd,
  output logic                                   count_overflow
);
  import ppfm_pkg::*;

  localparam int PW = COUNT_WIDTH + 1;
  localparam int CW = (PW > TPS_WIDTH) ? PW : TPS_WIDTH;

  back_state_t           state, state_next;
  logic [STEP_WIDTH-1:0] step;
  logic [PW-1:0]         period;
  logic                  sat;
  logic [TPS_WIDTH-1:0]  num;
  logic [PW-1:0]         rem;
  logic [TPS_WIDTH-1:0]  freq;
  logic [TPS_WIDTH-1:0]  per_shift;
  logic [BCD_WIDTH-1:0]  per_bcd;
  logic [BCD_WIDTH-1:0]  frq_bcd;

  logic [PW-1:0]         ld_period;
  logic [CW-1:0]         ld_wide;
  logic [TPS_WIDTH-1:0]  ld_clamped;
  logic [PW:0]           rem_sh;
  logic                  q_bit;
  logic                  out_free;
  logic                  last_step;

  assign ld_period  = {entry[COUNT_WIDTH:1], 1'b0};
  assign ld_wide    = CW'(ld_period);
  assign ld_clamped = (ld_wide > CW'(BCD_LIMIT)) ? BCD_LIMIT : ld_wide[TPS_WIDTH-1:0];
  assign rem_sh     = {rem, num[TPS_WIDTH-1]};
  assign q_bit      = (period != '0) && (rem_sh >= {1'b0, period});
  assign out_free   = !out_valid || out_ready;
  assign last_step  = (step == STEP_WIDTH'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (entry_avail) begin
          pop        = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (last_step) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      step      <= '0;
      period    <= ld_period;
      sat       <= entry[0];
      num       <= tps;
      rem       <= '0;
      freq      <= '0;
      per_shift <= ld_clamped;
      per_bcd   <= '0;
      frq_bcd   <= '0;
    end else if (state == BK_RUN) begin
      step      <= step + 1'b1;
      num       <= {num[TPS_WIDTH-2:0], 1'b0};
      rem       <= q_bit ? PW'(rem_sh - {1'b0, period}) : rem_sh[PW-1:0];
      freq      <= {freq[TPS_WIDTH-2:0], q_bit};
      frq_bcd   <= bcd_shift(frq_bcd, q_bit);
      per_shift <= {per_shift[TPS_WIDTH-2:0], 1'b0};
      per_bcd   <= bcd_shift(per_bcd, per_shift[TPS_WIDTH-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_DONE && out_free) begin
      period_ticks   <= PERIOD_OUT_WIDTH'(period);
      frequency_hz   <= freq[FREQ_WIDTH-1:0];
      period_bcd     <= per_bcd;
      frequency_bcd  <= frq_bcd;
      count_overflow <= sat;
    end
  end

endmodule

FILE: sv/pulse_period_frequency_meter.sv
// ----------------------------------------------------------------------------
// pulse_period_frequency_meter
// Gated-timer meter: high-time count per pulse, period, frequency and BCD.
// ----------------------------------------------------------------------------
// The block takes one timebase tick per cycle (in_ready is low only in reset
// and while both entries of the two-deep pulse queue are taken). After reset
// it skips a high phase in progress, then counts the high ticks of each pulse
// and on its falling edge queues the count. The back end turns each queued
// pulse into a result: a load step, the bit-serial divider (one quotient
// bit per cycle, BCD conversion of period and frequency in step with it)
// and a transfer into the output register once that register is free.
// The output register lets the next pulse be worked on while a result
// waits. ticks_per_second is loaded through cfg_wr_en / cfg_wr_data.
`timescale 1ns / 1ps

module pulse_period_frequency_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [ppfm_pkg::TPS_WIDTH-1:0]         cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   signal_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ppfm_pkg::PERIOD_OUT_WIDTH-1:0]  period_ticks,
  output logic [ppfm_pkg::FREQ_WIDTH-1:0]        frequency_hz,
  output logic [ppfm_pkg::BCD_WIDTH-1:0]         period_bcd,
  output logic [ppfm_pkg::BCD_WIDTH-1:0]         frequency_bcd,
  output logic                                   count_overflow
);
  import ppfm_pkg::*;

  logic [TPS_WIDTH-1:0]   ticks_per_second;
  logic                   tick;
  logic                   push;
  logic [COUNT_WIDTH:0]   push_data;
  logic                   pop;
  logic [COUNT_WIDTH:0]   pop_data;
  logic                   full;
  logic                   empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  assign in_ready = !rst && !full;
  assign tick     = in_valid && in_ready;

  ppfm_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .level     (signal_level),
    .push      (push),
    .push_data (push_data)
  );

  ppfm_fifo #(
    .WIDTH (COUNT_WIDTH + 1)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  ppfm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .tps            (ticks_per_second),
    .entry_avail    (!empty),
    .entry          (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .period_ticks   (period_ticks),
    .frequency_hz   (frequency_hz),
    .period_bcd     (period_bcd),
    .frequency_bcd  (frequency_bcd),
    .count_overflow (count_overflow)
  );

endmodule

FILE: sv/ppfm_checker.sv
// ----------------------------------------------------------------------------
// ppfm_checker
// Port-level checks on the result channel of the meter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_period_frequency_meter_assert.svh"

module ppfm_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [ppfm_pkg::PERIOD_OUT_WIDTH-1:0]  period_ticks,
  input logic [ppfm_pkg::FREQ_WIDTH-1:0]        frequency_hz,
  input logic [ppfm_pkg::BCD_WIDTH-1:0]         period_bcd,
  input logic [ppfm_pkg::BCD_WIDTH-1:0]         frequency_bcd
);
  import ppfm_pkg::*;

  function automatic logic bcd_ok(input logic [BCD_WIDTH-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (v[4*d +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  `PPFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(period_ticks) && $stable(frequency_hz), "result changed while stalled")
  `PPFM_ASSERT_ALWAYS(a_period_even, !out_valid || !period_ticks[0], "odd period")
  `PPFM_ASSERT_ALWAYS(a_bcd_digits, !out_valid || (bcd_ok(period_bcd) && bcd_ok(frequency_bcd)),
    "BCD digit above nine")

endmodule

bind pulse_period_frequency_meter ppfm_checker u_ppfm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .period_ticks  (period_ticks),
  .frequency_hz  (frequency_hz),
  .period_bcd    (period_bcd),
  .frequency_bcd (frequency_bcd)
);

FILE: tb/pulse_period_frequency_meter_test.sv
// ----------------------------------------------------------------------------
// Pulse period / frequency meter testbench
// Drives timebase ticks carrying the sampled level of a square wave and checks
// each reported pulse (period, frequency, both BCD forms, overflow flag)
// against typed-in values or a behavioral model of the gated counter. A
// directed table covers the skip after reset, the shortest pulse, the
// saturating count and the extreme tick rates. Random pulse trains with
// noise follow, run under several tick rates with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_period_frequency_meter_test;
  import ppfm_pkg::*;

  localparam int COUNT_BITS    = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_TICKS  = 1250;
  localparam int RATE_PHASES   = 6;
  localparam int LONG_PULSE    = 1000;
  localparam int TABLE_ROWS    = 14;

  typedef struct packed {
    logic [PERIOD_OUT_WIDTH-1:0] period;
    logic [FREQ_WIDTH-1:0]       freq;
    logic [BCD_WIDTH-1:0]        period_digits;
    logic [BCD_WIDTH-1:0]        freq_digits;
    logic                        overflow;
  } reading_t;

  typedef struct {
    bit                   set_rate;
    logic [TPS_WIDTH-1:0] rate;
    int unsigned          lead_high;
    int unsigned          lead_low;
    int unsigned          high_len;
    bit                   typed;
    reading_t             want;
  } pulse_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [TPS_WIDTH-1:0]        cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        signal_level = 1'b0;
  logic                        out_ready = 1'b0;
  logic                        in_ready;
  logic                        out_valid;
  logic [PERIOD_OUT_WIDTH-1:0] period_ticks;
  logic [FREQ_WIDTH-1:0]       frequency_hz;
  logic [BCD_WIDTH-1:0]        period_bcd;
  logic [BCD_WIDTH-1:0]        frequency_bcd;
  logic                        count_overflow;

  pulse_period_frequency_meter #(
    .COUNT_WIDTH(COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .signal_level  (signal_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .period_ticks  (period_ticks),
    .frequency_hz  (frequency_hz),
    .period_bcd    (period_bcd),
    .frequency_bcd (frequency_bcd),
    .count_overflow(count_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Meter model state
  front_state_t          meter_phase = PH_SKIP;
  logic [COUNT_BITS-1:0] high_ticks = '0;
  logic                  count_sat = 1'b0;
  logic [TPS_WIDTH-1:0]  tick_rate = TPS_RESET;

  reading_t    expected_readings[$];
  int unsigned error_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned rates_used = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  logic        last_level = 1'b0;

  // Expected readings typed in where they follow directly; zero rows use the model.
  pulse_row_t pulse_table[TABLE_ROWS] = '{
    '{1'b0, '0, 4, 2, 1, 1'b1, '{17'd2, 19'd500000, 24'h000002, 24'h500000, 1'b0}},
    '{1'b0, '0, 0, 0, 2, 1'b1, '{17'd4, 19'd250000, 24'h000004, 24'h250000, 1'b0}},
    '{1'b0, '0, 0, 3, 7, 1'b0, '0},
    '{1'b0, '0, 0, 1, 65535, 1'b1, '{17'd131070, 19'd7, 24'h131070, 24'h000007, 1'b0}},
    '{1'b0, '0, 0, 0, 65536, 1'b1, '{17'd131070, 19'd7, 24'h131070, 24'h000007, 1'b1}},
    '{1'b0, '0, 0, 2, 65600, 1'b0, '0},
    '{1'b1, 20'd0, 0, 0, 1, 1'b1, '{17'd2, 19'd0, 24'h000002, 24'h000000, 1'b0}},
    '{1'b1, 20'd1048575, 0, 0, 1, 1'b1, '{17'd2, 19'd524287, 24'h000002, 24'h524287, 1'b0}},
    '{1'b0, '0, 0, 1, 65535, 1'b0, '0},
    '{1'b1, 20'd1000, 0, 0, 1, 1'b1, '{17'd2, 19'd500, 24'h000002, 24'h000500, 1'b0}},
    '{1'b0, '0, 0, 0, 501, 1'b1, '{17'd1002, 19'd0, 24'h001002, 24'h000000, 1'b0}},
    '{1'b0, '0, 0, 4, 500, 1'b0, '0},
    '{1'b1, 20'd1000000, 0, 0, 3, 1'b0, '0},
    '{1'b0, '0, 0, 0, 12345, 1'b0, '0}
  };

  function automatic logic [BCD_WIDTH-1:0] packed_digits(input int unsigned value);
    logic [BCD_WIDTH-1:0] digits;
    int unsigned          rest;
    digits = '0;
    rest = (value > BCD_LIMIT) ? BCD_LIMIT : value;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      digits[4*d +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
    return digits;
  endfunction

  // One tick into the meter model; returns 1 when the tick closes a pulse.
  function automatic bit advance_meter(input logic level, output reading_t res);
    int unsigned full_period;
    int unsigned rate_quot;
    res = '0;
    case (meter_phase)
      PH_WAIT: begin
        if (level) begin
          meter_phase = PH_COUNT;
          high_ticks = COUNT_BITS'(1);
          count_sat = 1'b0;
        end
        return 1'b0;
      end
      PH_COUNT: begin
        if (level) begin
          if (&high_ticks) begin
            count_sat = 1'b1;
          end else begin
            high_ticks = high_ticks + 1'b1;
          end
          return 1'b0;
        end
        full_period = 2 * high_ticks;
        rate_quot = (full_period != 0) ? tick_rate / full_period : 0;
        res.period = full_period[PERIOD_OUT_WIDTH-1:0];
        res.freq = rate_quot[FREQ_WIDTH-1:0];
        res.period_digits = packed_digits(full_period);
        res.freq_digits = packed_digits(rate_quot);
        res.overflow = count_sat;
        high_ticks = '0;
        count_sat = 1'b0;
        meter_phase = PH_WAIT;
        return 1'b1;
      end
      default: begin
        meter_phase = level ? PH_SKIP : PH_WAIT;
        return 1'b0;
      end
    endcase
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_tick(input logic level, input bit typed, input reading_t want);
    reading_t    predicted;
    int unsigned gap;
    in_valid <= 1'b1;
    signal_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    last_level = level;
    if (advance_meter(level, predicted)) begin
      expected_readings.push_back(typed ? want : predicted);
    end
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pulse(input int unsigned lead_high, input int unsigned lead_low,
                            input int unsigned high_len, input bit typed,
                            input reading_t want);
    repeat (lead_high) send_tick(1'b1, 1'b0, '0);
    repeat (lead_low) send_tick(1'b0, 1'b0, '0);
    repeat (high_len) send_tick(1'b1, 1'b0, '0);
    send_tick(1'b0, typed, want);
  endtask

  // Sender holds off until every pending reading is back and the back end is done.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate(input logic [TPS_WIDTH-1:0] rate);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_rate = rate;
    rates_used++;
  endtask

  initial begin : stimulus
    int unsigned          phase_end;
    int unsigned          kind;
    int unsigned          lead;
    int unsigned          high_len;
    logic [TPS_WIDTH-1:0] rate;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_ROWS; i++) begin
      if (pulse_table[i].set_rate) set_rate(pulse_table[i].rate);
      quiet = (pulse_table[i].high_len > LONG_PULSE);
      send_pulse(pulse_table[i].lead_high, pulse_table[i].lead_low,
                 pulse_table[i].high_len, pulse_table[i].typed, pulse_table[i].want);
    end
    quiet = 1'b0;

    phase_end = ticks_sent;
    for (int p = 0; p < RATE_PHASES; p++) begin
      case (p)
        1: rate = 20'd1000;
        2: rate = TPS_RESET;
        4: rate = '1;
        default: rate = TPS_WIDTH'($urandom_range(1000, 1000000));
      endcase
      set_rate(rate);
      quiet = (p == 2);
      phase_end += RANDOM_TICKS / RATE_PHASES;
      while (ticks_sent < phase_end) begin
        kind = $urandom_range(99);
        if (kind < 12) begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)), 1'b0, '0);
        end else begin
          lead = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
          if (kind < 80) high_len = $urandom_range(1, 8);
          else if (kind < 97) high_len = $urandom_range(9, 60);
          else high_len = $urandom_range(61, 400);
          send_pulse(0, lead, high_len, 1'b0, '0);
        end
      end
      if (last_level) send_tick(1'b0, 1'b0, '0);
    end
    quiet = 1'b0;

    wait_idle();
    $display("sent %0d ticks, checked %0d readings under %0d tick-rate settings",
             ticks_sent, readings_checked, rates_used);
    $display("covered reset skip, shortest and saturating pulses, zero and full-scale rates");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin : reading_monitor
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: period_ticks 0x%0h", period_ticks);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("period_ticks", want.period, period_ticks);
        check_field("frequency_hz", want.freq, frequency_hz);
        check_field("period_bcd", want.period_digits, period_bcd);
        check_field("frequency_bcd", want.freq_digits, frequency_bcd);
        check_field("count_overflow", want.overflow, count_overflow);
        readings_checked++;
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = quiet ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
